// ----- rtl/fsap_pkg.sv -----
// Shared types, constants and rounding helpers for the filtered speed/angle PID core.
package fsap_pkg;

  localparam int DIV_W = 64;
  localparam int COEF_SHIFT = 24;
  localparam logic signed [31:0] COEF_KEEP = 32'sd14327742;
  localparam logic signed [31:0] COEF_NEW = 32'sd1221381;

  localparam logic [2:0] REG_GAIN_P = 3'd0;
  localparam logic [2:0] REG_GAIN_I = 3'd1;
  localparam logic [2:0] REG_GAIN_D = 3'd2;
  localparam logic [2:0] REG_DRIVE_MIN = 3'd3;
  localparam logic [2:0] REG_DRIVE_MAX = 3'd4;
  localparam logic [2:0] REG_ANGLE_LIMIT = 3'd5;
  localparam logic [2:0] REG_COUNTS_PER_REV = 3'd6;
  localparam logic [2:0] REG_LOOP_MODE = 3'd7;

  localparam logic [1:0] MODE_ANGLE = 2'd1;
  localparam logic [1:0] MODE_ANGLE_SPEED = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_AHI, ST_ALO, ST_AGOAL, ST_AEDT, ST_AINT,
    ST_CPR, ST_VDIV, ST_VWAIT, ST_F0, ST_F1, ST_F2, ST_F3,
    ST_ERR, ST_EDT, ST_SINT, ST_DWAIT,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_FIN
  } state_t;

  // Saturate a 64-bit signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Right shift rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int sh);
    logic [63:0] mag;
    logic [63:0] q;
    logic signed [63:0] r;
    mag = v[63] ? (64'd0 - v) : v;
    q = (mag + (64'd1 << (sh - 1))) >> sh;
    r = v[63] ? $signed(64'd0 - q) : $signed(q);
    return r;
  endfunction

endpackage

// ----- rtl/fsap_mul.sv -----
// Shared registered 32x32 signed multiplier.
module fsap_mul
  import fsap_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- rtl/fsap_div.sv -----
// Shared bit-serial divider with round-to-nearest, ties away from zero.
module fsap_div
  import fsap_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] num,
  input  logic        [DIV_W-1:0] den,
  output logic                    done,
  output logic signed [DIV_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_W) + 1;

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] qb;
  logic [DIV_W-1:0] dv;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;
  logic [DIV_W-1:0] mag;

  assign mag = (num[DIV_W-1] ? (DIV_W'(0) - num) : num) + (den >> 1);
  assign rem_sh = {rem, qb[DIV_W-1]};
  assign diff = rem_sh - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qb <= mag;
      dv <= den;
      neg <= num[DIV_W-1];
    end else if (busy) begin
      if (!diff[DIV_W]) begin
        rem <= diff[DIV_W-1:0];
        qb <= {qb[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIV_W-1:0];
        qb <= {qb[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quo = neg ? $signed(DIV_W'(0) - qb) : $signed(qb);

endmodule

// ----- rtl/filtered_speed_angle_pid_core.sv -----
// Filtered speed/angle PID core: sequencer around one multiplier and one divider.
// Most of the time of a speed step goes to its two bit-serial divisions.
// in_ready is high only in idle, so a new item is accepted only after the last one has finished.
// A result still waiting in the output register holds the sequencer in its last state.
// Synchronous reset restores the configuration registers, the loop state and out_valid.
module filtered_speed_angle_pid_core
  import fsap_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] angle_setpoint,
  input  logic signed [31:0] speed_setpoint,
  input  logic signed [31:0] enc_count,
  input  logic        [30:0] delta_t,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive,
  output logic signed [31:0] filtered_velocity
);

  localparam logic signed [63:0] LIM = 64'sd125 <<< FRAC_BITS;

  logic signed [31:0] gain_p, gain_i, gain_d, drive_min, drive_max;
  logic        [30:0] angle_limit;
  logic        [19:0] counts_per_rev;
  logic        [1:0]  loop_mode;

  logic signed [31:0] last_enc, last_raw_velocity, smoothed_velocity, error_sum, last_error;
  logic signed [31:0] t_ang, t_spd, enc;
  logic        [30:0] dt;
  logic signed [31:0] err, der, vel, res;
  logic signed [63:0] acc;
  logic               ph_ang;

  state_t state, state_next;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               div_start, div_done;
  logic signed [63:0] div_num, div_quo;
  logic        [63:0] div_den;

  logic signed [63:0] prod_r, pid_u, sum_e, goal_e, int_s;
  logic signed [63:0] lim_a;

  logic        [31:0] ang_mag;
  logic        [32:0] ang_x;
  logic        [17:0] ang_y;
  logic        [63:0] ang_q;
  logic signed [63:0] ang_goal;

  fsap_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  fsap_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign cfg_ready = 1'b1;
  assign in_ready = (state == ST_IDLE);

  assign prod_r = rnd_shr(prod, FRAC_BITS);
  assign pid_u = acc + prod_r;
  assign sum_e = 64'(error_sum) + prod_r;
  assign int_s = (sum_e > LIM) ? LIM : ((sum_e < -LIM) ? -LIM : sum_e);
  assign lim_a = {33'd0, angle_limit};

  // The angle goal is round(32*|t|/3) = 10*|t| + floor((2*|t|+1)/3). The last term is
  // split at bit 16: x/3 = 21845*x_hi + (x_hi + x_lo)/3, and the small quotient comes
  // from a multiply by ceil(2^20/3) and a shift by 20.
  assign ang_mag = t_ang[31] ? (32'd0 - t_ang) : t_ang;
  assign ang_x = {ang_mag, 1'b1};
  assign ang_y = {1'b0, ang_x[32:16]} + {2'b00, ang_x[15:0]};
  assign ang_q = ({32'd0, ang_mag} << 3) + ({32'd0, ang_mag} << 1) + $unsigned(acc)
               + ($unsigned(prod) >> 20);
  assign ang_goal = t_ang[31] ? -$signed(ang_q) : $signed(ang_q);
  assign goal_e = ang_goal - 64'(enc);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
      drive_min <= -32'sd16711680;
      drive_max <= 32'sd16711680;
      angle_limit <= 31'd16711680;
      counts_per_rev <= 20'd3840;
      loop_mode <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_P: gain_p <= cfg_data;
        REG_GAIN_I: gain_i <= cfg_data;
        REG_GAIN_D: gain_d <= cfg_data;
        REG_DRIVE_MIN: drive_min <= cfg_data;
        REG_DRIVE_MAX: drive_max <= cfg_data;
        REG_ANGLE_LIMIT: angle_limit <= cfg_data[30:0];
        REG_COUNTS_PER_REV: counts_per_rev <= cfg_data[19:0];
        REG_LOOP_MODE: loop_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (loop_mode == MODE_ANGLE || loop_mode == MODE_ANGLE_SPEED) begin
            state_next = ST_AHI;
          end else begin
            state_next = ST_CPR;
          end
        end
      end
      ST_AHI: begin
        mul_a = {15'd0, ang_x[32:16]};
        mul_b = 32'sd21845;
        state_next = ST_ALO;
      end
      ST_ALO: begin
        mul_a = {14'd0, ang_y};
        mul_b = 32'sd349526;
        state_next = ST_AGOAL;
      end
      ST_AGOAL: state_next = ST_AEDT;
      ST_AEDT: begin
        mul_a = err;
        mul_b = {1'b0, dt};
        state_next = ST_AINT;
      end
      ST_AINT: state_next = ST_P0;
      ST_CPR: begin
        mul_a = {1'b0, dt};
        mul_b = (counts_per_rev == '0) ? 32'sd1 : {12'd0, counts_per_rev};
        state_next = ST_VDIV;
      end
      ST_VDIV: begin
        div_start = 1'b1;
        div_num = (64'(enc) - 64'(last_enc)) <<< FRAC_BITS;
        div_den = prod;
        state_next = ST_VWAIT;
      end
      ST_VWAIT: if (div_done) state_next = ST_F0;
      ST_F0: begin
        mul_a = COEF_KEEP;
        mul_b = smoothed_velocity;
        state_next = ST_F1;
      end
      ST_F1: begin
        mul_a = COEF_NEW;
        mul_b = vel;
        state_next = ST_F2;
      end
      ST_F2: begin
        mul_a = COEF_NEW;
        mul_b = last_raw_velocity;
        state_next = ST_F3;
      end
      ST_F3: state_next = ST_ERR;
      ST_ERR: state_next = ST_EDT;
      ST_EDT: begin
        mul_a = err;
        mul_b = {1'b0, dt};
        state_next = ST_SINT;
      end
      ST_SINT: begin
        div_start = 1'b1;
        div_num = (64'(err) - 64'(last_error)) <<< FRAC_BITS;
        div_den = {33'd0, dt};
        state_next = ST_DWAIT;
      end
      ST_DWAIT: if (div_done) state_next = ST_P0;
      ST_P0: begin
        mul_a = gain_p;
        mul_b = err;
        state_next = ST_P1;
      end
      ST_P1: begin
        mul_a = gain_i;
        mul_b = error_sum;
        state_next = ST_P2;
      end
      ST_P2: begin
        mul_a = gain_d;
        mul_b = der;
        state_next = ST_P3;
      end
      ST_P3: begin
        if (ph_ang && loop_mode == MODE_ANGLE_SPEED) begin
          state_next = ST_CPR;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Loop state and per-item working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_enc <= '0;
      last_raw_velocity <= '0;
      smoothed_velocity <= '0;
      error_sum <= '0;
      last_error <= '0;
      ph_ang <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            t_ang <= angle_setpoint;
            t_spd <= speed_setpoint;
            enc <= enc_count;
            dt <= (delta_t == '0) ? 31'd1 : delta_t;
            ph_ang <= (loop_mode == MODE_ANGLE || loop_mode == MODE_ANGLE_SPEED);
          end
        end
        ST_ALO: acc <= prod;
        ST_AGOAL: begin
          err <= sat32(goal_e);
          der <= sat32(64'(sat32(goal_e)) - 64'(last_error));
        end
        ST_AINT: begin
          error_sum <= sat32(sum_e);
          last_error <= err;
        end
        ST_VWAIT: begin
          if (div_done) begin
            vel <= sat32(div_quo);
            last_enc <= enc;
          end
        end
        ST_F1: acc <= prod;
        ST_F2: acc <= acc + prod;
        ST_F3: begin
          smoothed_velocity <= sat32(rnd_shr(acc + prod, COEF_SHIFT));
          last_raw_velocity <= vel;
        end
        ST_ERR: err <= sat32(64'(t_spd) - 64'(smoothed_velocity));
        ST_SINT: error_sum <= int_s[31:0];
        ST_DWAIT: begin
          if (div_done) begin
            der <= sat32(div_quo);
            last_error <= err;
          end
        end
        ST_P1: acc <= prod_r;
        ST_P2: acc <= pid_u;
        ST_P3: begin
          if (ph_ang) begin
            ph_ang <= 1'b0;
            if (pid_u > lim_a) begin
              res <= lim_a[31:0];
            end else if (pid_u < -lim_a) begin
              res <= 32'(-lim_a);
            end else begin
              res <= pid_u[31:0];
            end
          end else begin
            if (pid_u < 64'(drive_min) || 64'(drive_max) < 64'(drive_min)) begin
              res <= drive_min;
            end else if (pid_u > 64'(drive_max)) begin
              res <= drive_max;
            end else begin
              res <= pid_u[31:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!out_valid || out_ready)) begin
      drive <= res;
      filtered_velocity <= smoothed_velocity;
    end
  end

endmodule
